// ----- hdl/esf_pkg.sv -----
// types and constants shared by the escape sequence framer
`timescale 1ns / 1ps

package esf_pkg;

  localparam logic [7:0] BYTE_BEL      = 8'h07;
  localparam logic [7:0] BYTE_ESC      = 8'h1b;
  localparam logic [7:0] BYTE_BSL      = 8'h5c;
  localparam logic [7:0] BYTE_LBRACKET = 8'h5b;
  localparam logic [7:0] BYTE_RBRACKET = 8'h5d;
  localparam logic [7:0] BYTE_DCS      = 8'h50;
  localparam logic [7:0] BYTE_PM       = 8'h5e;
  localparam logic [7:0] BYTE_APC      = 8'h5f;
  localparam logic [7:0] BYTE_G0       = 8'h28;
  localparam logic [7:0] BYTE_G1       = 8'h29;
  localparam logic [7:0] BYTE_G2       = 8'h2a;
  localparam logic [7:0] BYTE_G3       = 8'h2b;
  localparam logic [7:0] FINAL_LO      = 8'h40;
  localparam logic [7:0] FINAL_HI      = 8'h7e;

  typedef enum logic [2:0] {
    PH_GROUND  = 3'd0,
    PH_ESC     = 3'd1,
    PH_CSI     = 3'd2,
    PH_OSC     = 3'd3,
    PH_OSC_ESC = 3'd4,
    PH_STR     = 3'd5,
    PH_STR_ESC = 3'd6,
    PH_CHARSET = 3'd7
  } phase_t;

  typedef enum logic [3:0] {
    KIND_TEXT      = 4'd0,
    KIND_ABSORB    = 4'd1,
    KIND_CSI_PARAM = 4'd2,
    KIND_CSI_FINAL = 4'd3,
    KIND_OSC_BYTE  = 4'd4,
    KIND_OSC_END   = 4'd5,
    KIND_STR_END   = 4'd6,
    KIND_SINGLE    = 4'd7,
    KIND_CHARSET   = 4'd8
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] tok_byte;
    logic [7:0] intro;
    logic       last;
  } token_t;

  typedef struct packed {
    token_t     first;
    token_t     second;
    logic       two;
    phase_t     phase;
    logic [7:0] intro;
  } dec_t;

endpackage

// ----- hdl/escape_sequence_framer_unit.sv -----
// top level of the escape sequence framer
//
// channel  direction  ports
// in       input      in_valid, in_ready, in_byte
// out      output     out_valid, out_ready, out_token_kind, out_token_byte,
//                     out_intro_byte, out_last_of_run
//
// one byte is classified in the cycle it is transferred; its result appears
// in the result register on the next cycle. a byte that yields two results
// holds the second in a pending register, and input waits until it moves on.
// otherwise one byte per cycle while out_ready is high.
// synchronous active-low reset returns to ground with intro cleared.
// input waits while a held result sees out_ready low, and while the pending slot is in use
`timescale 1ns / 1ps

module escape_sequence_framer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_token_kind,
  output logic [7:0] out_token_byte,
  output logic [7:0] out_intro_byte,
  output logic       out_last_of_run
);
  import esf_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] intro_r, intro_nxt;
  token_t     out_r, out_nxt;
  token_t     pend_r, pend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  dec_t       dec;
  logic       in_fire;
  logic       out_fire;

  esf_decode u_decode (
    .phase   (phase_r),
    .intro   (intro_r),
    .in_byte (in_byte),
    .dec     (dec)
  );

  assign in_ready = !pend_valid_r && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  always_comb begin
    phase_nxt      = phase_r;
    intro_nxt      = intro_r;
    out_nxt        = out_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    pend_valid_nxt = pend_valid_r;
    if (out_fire) begin
      if (pend_valid_r) begin
        out_nxt        = pend_r;
        pend_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (in_fire) begin
      phase_nxt      = dec.phase;
      intro_nxt      = dec.intro;
      out_nxt        = dec.first;
      out_valid_nxt  = 1'b1;
      pend_nxt       = dec.second;
      pend_valid_nxt = dec.two;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_GROUND;
      intro_r      <= 8'h00;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      intro_r      <= intro_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_token_kind  = out_r.kind;
  assign out_token_byte  = out_r.tok_byte;
  assign out_intro_byte  = out_r.intro;
  assign out_last_of_run = out_r.last;

endmodule

// ----- hdl/esf_decode.sv -----
// byte classifier: next phase, intro and up to two tokens for one byte
`timescale 1ns / 1ps

module esf_decode (
  input  esf_pkg::phase_t phase,
  input  logic [7:0]      intro,
  input  logic [7:0]      in_byte,
  output esf_pkg::dec_t   dec
);
  import esf_pkg::*;

  token_t     osc_tok;
  phase_t     osc_phase;

  // osc payload byte handling, shared by the osc and osc-after-esc phases
  always_comb begin
    osc_tok.tok_byte = in_byte;
    osc_tok.intro    = intro;
    osc_tok.last     = 1'b1;
    if (in_byte == BYTE_BEL) begin
      osc_tok.kind = KIND_OSC_END;
      osc_phase    = PH_GROUND;
    end else if (in_byte == BYTE_ESC) begin
      osc_tok.kind = KIND_ABSORB;
      osc_phase    = PH_OSC_ESC;
    end else begin
      osc_tok.kind = KIND_OSC_BYTE;
      osc_phase    = PH_OSC;
    end
  end

  always_comb begin
    dec.first.kind     = KIND_ABSORB;
    dec.first.tok_byte = in_byte;
    dec.first.intro    = intro;
    dec.first.last     = 1'b1;
    dec.second         = osc_tok;
    dec.two            = 1'b0;
    dec.phase          = phase;
    dec.intro          = intro;
    case (phase)
      PH_GROUND: begin
        dec.first.intro = 8'h00;
        if (in_byte == BYTE_ESC) begin
          dec.phase = PH_ESC;
        end else begin
          dec.first.kind = KIND_TEXT;
        end
      end
      PH_ESC: begin
        dec.intro       = in_byte;
        dec.first.intro = in_byte;
        if (in_byte == BYTE_LBRACKET) begin
          dec.phase = PH_CSI;
        end else if (in_byte == BYTE_RBRACKET) begin
          dec.phase = PH_OSC;
        end else if (in_byte == BYTE_DCS || in_byte == BYTE_PM || in_byte == BYTE_APC) begin
          dec.phase = PH_STR;
        end else if (in_byte == BYTE_G0 || in_byte == BYTE_G1 ||
                     in_byte == BYTE_G2 || in_byte == BYTE_G3) begin
          dec.phase = PH_CHARSET;
        end else begin
          dec.phase      = PH_GROUND;
          dec.first.kind = KIND_SINGLE;
        end
      end
      PH_CSI: begin
        if (in_byte >= FINAL_LO && in_byte <= FINAL_HI) begin
          dec.phase      = PH_GROUND;
          dec.first.kind = KIND_CSI_FINAL;
        end else begin
          dec.first.kind = KIND_CSI_PARAM;
        end
      end
      PH_OSC: begin
        dec.first = osc_tok;
        dec.phase = osc_phase;
      end
      PH_OSC_ESC: begin
        if (in_byte == BYTE_BSL) begin
          dec.phase      = PH_GROUND;
          dec.first.kind = KIND_OSC_END;
        end else begin
          // lone esc goes out as payload, then this byte is handled as in the osc phase
          dec.first.kind     = KIND_OSC_BYTE;
          dec.first.tok_byte = BYTE_ESC;
          dec.first.last     = 1'b0;
          dec.two            = 1'b1;
          dec.phase          = osc_phase;
        end
      end
      PH_STR: begin
        if (in_byte == BYTE_ESC) begin
          dec.phase = PH_STR_ESC;
        end
      end
      PH_STR_ESC: begin
        if (in_byte == BYTE_BSL) begin
          dec.phase      = PH_GROUND;
          dec.first.kind = KIND_STR_END;
        end else if (in_byte == BYTE_ESC) begin
          dec.phase = PH_STR_ESC;
        end else begin
          dec.phase = PH_STR;
        end
      end
      PH_CHARSET: begin
        dec.phase      = PH_GROUND;
        dec.first.kind = KIND_CHARSET;
      end
      default: begin
        dec.phase = PH_GROUND;
      end
    endcase
  end

endmodule
